// ----- sv/process_id_table_macros.svh -----
// assertion macros for the process id table checker
`ifndef PROCESS_ID_TABLE_MACROS_SVH
`define PROCESS_ID_TABLE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define PIT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// antecedent in one cycle implies consequent in the next
`define PIT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/pit_pkg.sv -----
// shared types and constants of the process id table
`default_nettype none

package pit_pkg;

	localparam int NUM_IDS_DEF       = 256;
	localparam int FIRST_FREE_ID_DEF = 2;
	localparam int INIT_ID_DEF       = 0;
	localparam int KERNEL_ID_DEF     = 1;

	localparam int PID_W    = 8;
	localparam int RPID_W   = 9;
	localparam int STATUS_W = 32;

	localparam logic [STATUS_W-1:0] DESTROY_STATUS = 32'h0000_dead;
	localparam logic [STATUS_W-1:0] STATUS_NONE    = '1;
	localparam logic [RPID_W-1:0]   RPID_NONE      = '1;

	typedef enum logic [1:0] {
		MODE_ALLOC,
		MODE_DESTROY,
		MODE_EXIT,
		MODE_WAIT
	} mode_t;

	typedef enum logic [2:0] {
		ERR_OK,
		ERR_NOFREE,
		ERR_NOSUCH,
		ERR_NOTCHILD,
		ERR_MUSTWAIT,
		ERR_INVALID
	} err_t;

	typedef struct packed {
		logic             used;
		logic             exited;
		logic [PID_W-1:0] parent;
	} meta_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DESTROY,
		ST_EXIT_CHK,
		ST_EXIT_SCAN,
		ST_EXIT_FIN,
		ST_ALLOC_SCAN,
		ST_WAIT_T,
		ST_WAIT_C
	} state_t;

endpackage

`default_nettype wire

// ----- sv/pit_ram.sv -----
// generic single-port-write ram with registered read
`default_nettype none

module pit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/process_id_table.sv -----
// process id table: allocate, destroy, exit and wait on process ids
//
// usage
//  - command channel: an item (mode, current_pid, target_pid, exit_value) is
//    taken at a rising edge where start is high and busy is low
//  - result channel: done is high for exactly one cycle with error_code,
//    result_pid and status_value; the receiver cannot hold it off, so the
//    block never waits on the output side
//  - an item that fails its first checks (bad caller, id outside the table,
//    reserved target) answers with done in the next cycle and busy never rises
//  - destroy reads the target entry, wait the target and then the caller entry
//  - allocate walks the entry ram from FIRST_FREE_ID, one read per cycle,
//    and answers as soon as a free entry is seen
//  - exit walks the whole entry ram with one read-modify-write per cycle,
//    then marks the caller exited and answers
//  - the single read port of the entry ram makes these walks one read at a time
//  - one item at a time: busy stays high until its result is out, and a new
//    item may be taken in the cycle where done is high
//  - after reset a clearing pass writes every entry ram word with busy high,
//    leaving only the kernel entry in use
`default_nettype none

module process_id_table #(
	parameter int NUM_IDS       = pit_pkg::NUM_IDS_DEF,
	parameter int FIRST_FREE_ID = pit_pkg::FIRST_FREE_ID_DEF,
	parameter int INIT_ID       = pit_pkg::INIT_ID_DEF,
	parameter int KERNEL_ID     = pit_pkg::KERNEL_ID_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    mode,
	input  wire logic [pit_pkg::PID_W-1:0]     current_pid,
	input  wire logic [pit_pkg::PID_W-1:0]     target_pid,
	input  wire logic [pit_pkg::STATUS_W-1:0]  exit_value,
	output logic                               done,
	output logic [2:0]                         error_code,
	output logic [pit_pkg::RPID_W-1:0]         result_pid,
	output logic [pit_pkg::STATUS_W-1:0]       status_value
);

	localparam int AW  = $clog2(NUM_IDS);
	localparam int PW  = pit_pkg::PID_W;
	localparam int RW  = pit_pkg::RPID_W;
	localparam int SW  = pit_pkg::STATUS_W;
	localparam int MW  = $bits(pit_pkg::meta_t);

	localparam logic [AW-1:0] LAST_IDX   = AW'(NUM_IDS - 1);
	localparam logic [AW-1:0] FIRST_IDX  = AW'(FIRST_FREE_ID);
	localparam logic [AW-1:0] KERNEL_IDX = AW'(KERNEL_ID);
	localparam logic [PW-1:0] INIT_PID   = PW'(INIT_ID);
	// no allocatable entry at all when the free range starts past the table
	localparam bit ALLOC_EMPTY = (FIRST_FREE_ID >= NUM_IDS);

	// control state
	pit_pkg::state_t state_q, state_d;
	logic [AW-1:0]   rd_idx_q, rd_idx_d;
	logic            chk_vld_s1, chk_vld_d;
	logic            done_q;

	// payload
	logic [PW-1:0]        cur_q;
	logic [PW-1:0]        tgt_q;
	logic [SW-1:0]        xval_q;
	pit_pkg::meta_t       meta_q, meta_d;
	logic [AW-1:0]        chk_idx_s1;
	pit_pkg::err_t        err_q;
	logic [RW-1:0]        rpid_q;
	logic [SW-1:0]        stat_q;

	// ram ports
	logic           meta_we, meta_re;
	logic [AW-1:0]  meta_waddr, meta_raddr;
	pit_pkg::meta_t meta_wdata;
	logic [MW-1:0]  meta_rdata;
	pit_pkg::meta_t m;
	logic           st_we, st_re;
	logic [AW-1:0]  st_waddr, st_raddr;
	logic [SW-1:0]  st_wdata, st_rdata;

	// result of this cycle
	logic           rsp;
	pit_pkg::err_t  rsp_err;
	logic [RW-1:0]  rsp_pid;
	logic [SW-1:0]  rsp_stat;

	logic           accept;
	logic           cur_in_tab, tgt_in_tab;
	logic           rd_ok;
	logic [AW-1:0]  cur_idx, tgt_idx;

	assign busy       = (state_q != pit_pkg::ST_IDLE);
	assign accept     = start && !busy;
	assign cur_in_tab = 32'(current_pid) < NUM_IDS;
	assign tgt_in_tab = 32'(target_pid) < NUM_IDS;
	assign rd_ok      = 32'(rd_idx_q) < NUM_IDS;
	assign cur_idx    = AW'(cur_q);
	assign tgt_idx    = AW'(tgt_q);
	assign m          = pit_pkg::meta_t'(meta_rdata);

	pit_ram #(
		.WIDTH(MW),
		.DEPTH(NUM_IDS)
	) u_meta_ram (
		.clk  (clk),
		.we   (meta_we),
		.waddr(meta_waddr),
		.wdata(meta_wdata),
		.re   (meta_re),
		.raddr(meta_raddr),
		.rdata(meta_rdata)
	);

	// exit status per entry, its value used only after it has been written
	pit_ram #(
		.WIDTH(SW),
		.DEPTH(NUM_IDS)
	) u_status_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.re   (st_re),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	always_comb begin
		state_d    = state_q;
		rd_idx_d   = rd_idx_q;
		chk_vld_d  = chk_vld_s1;
		meta_d     = meta_q;
		meta_we    = 1'b0;
		meta_waddr = chk_idx_s1;
		meta_wdata = '{used: 1'b0, exited: 1'b0, parent: INIT_PID};
		meta_re    = 1'b0;
		meta_raddr = rd_idx_q;
		st_we      = 1'b0;
		st_waddr   = tgt_idx;
		st_wdata   = xval_q;
		st_re      = 1'b0;
		st_raddr   = AW'(target_pid);
		rsp        = 1'b0;
		rsp_err    = pit_pkg::ERR_OK;
		rsp_pid    = pit_pkg::RPID_NONE;
		rsp_stat   = '0;

		unique case (state_q)
			// one entry per cycle, kernel entry comes out in use
			pit_pkg::ST_CLEAR: begin
				meta_we    = 1'b1;
				meta_waddr = rd_idx_q;
				meta_wdata = '{used: (rd_idx_q == KERNEL_IDX), exited: 1'b0,
					parent: INIT_PID};
				rd_idx_d   = AW'(rd_idx_q + 1'b1);
				if (rd_idx_q == LAST_IDX) begin
					state_d = pit_pkg::ST_IDLE;
				end
			end

			pit_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (pit_pkg::mode_t'(mode))
						pit_pkg::MODE_ALLOC: begin
							if (current_pid == INIT_PID) begin
								rsp     = 1'b1;
								rsp_err = pit_pkg::ERR_INVALID;
							end else if (ALLOC_EMPTY) begin
								rsp     = 1'b1;
								rsp_err = pit_pkg::ERR_NOFREE;
							end else begin
								rd_idx_d  = FIRST_IDX;
								chk_vld_d = 1'b0;
								state_d   = pit_pkg::ST_ALLOC_SCAN;
							end
						end
						pit_pkg::MODE_DESTROY: begin
							if (32'(target_pid) < FIRST_FREE_ID) begin
								rsp     = 1'b1;
								rsp_err = pit_pkg::ERR_INVALID;
							end else if (!tgt_in_tab) begin
								rsp     = 1'b1;
								rsp_err = pit_pkg::ERR_NOSUCH;
							end else begin
								meta_re    = 1'b1;
								meta_raddr = AW'(target_pid);
								state_d    = pit_pkg::ST_DESTROY;
							end
						end
						pit_pkg::MODE_EXIT: begin
							if (current_pid == INIT_PID) begin
								rsp     = 1'b1;
								rsp_err = pit_pkg::ERR_INVALID;
							end else if (!cur_in_tab) begin
								rsp     = 1'b1;
								rsp_err = pit_pkg::ERR_NOSUCH;
							end else begin
								meta_re    = 1'b1;
								meta_raddr = AW'(current_pid);
								state_d    = pit_pkg::ST_EXIT_CHK;
							end
						end
						pit_pkg::MODE_WAIT: begin
							if (!tgt_in_tab || !cur_in_tab) begin
								rsp     = 1'b1;
								rsp_err = pit_pkg::ERR_NOSUCH;
							end else begin
								// status is read now and held in the ram output
								meta_re    = 1'b1;
								meta_raddr = AW'(target_pid);
								st_re      = 1'b1;
								st_raddr   = AW'(target_pid);
								state_d    = pit_pkg::ST_WAIT_T;
							end
						end
						default: begin
							state_d = pit_pkg::ST_IDLE;
						end
					endcase
				end
			end

			pit_pkg::ST_DESTROY: begin
				rsp     = 1'b1;
				state_d = pit_pkg::ST_IDLE;
				if (!m.used) begin
					rsp_err = pit_pkg::ERR_NOSUCH;
				end else if (m.parent != cur_q) begin
					rsp_err = pit_pkg::ERR_NOTCHILD;
				end else if (m.exited) begin
					rsp_err = pit_pkg::ERR_INVALID;
				end else begin
					meta_we    = 1'b1;
					meta_waddr = tgt_idx;
					st_we      = 1'b1;
					st_waddr   = tgt_idx;
					st_wdata   = pit_pkg::DESTROY_STATUS;
				end
			end

			pit_pkg::ST_EXIT_CHK: begin
				if (!m.used) begin
					rsp     = 1'b1;
					rsp_err = pit_pkg::ERR_NOSUCH;
					state_d = pit_pkg::ST_IDLE;
				end else if (m.exited) begin
					rsp     = 1'b1;
					rsp_err = pit_pkg::ERR_INVALID;
					state_d = pit_pkg::ST_IDLE;
				end else begin
					meta_d    = m;
					rd_idx_d  = '0;
					chk_vld_d = 1'b0;
					state_d   = pit_pkg::ST_EXIT_SCAN;
				end
			end

			// read entry i while entry i-1 is checked and written back
			pit_pkg::ST_EXIT_SCAN: begin
				meta_re    = rd_ok;
				meta_raddr = rd_idx_q;
				rd_idx_d   = AW'(rd_idx_q + 1'b1);
				chk_vld_d  = 1'b1;
				if (chk_vld_s1) begin
					if (m.used && (m.parent == cur_q)) begin
						// hand to init, an exited child is freed outright
						meta_we    = 1'b1;
						meta_wdata = '{used: !m.exited, exited: 1'b0, parent: INIT_PID};
						if (chk_idx_s1 == cur_idx) begin
							meta_d.parent = INIT_PID;
						end
					end
					if (chk_idx_s1 == LAST_IDX) begin
						state_d = pit_pkg::ST_EXIT_FIN;
					end
				end
			end

			// mark the caller exited, an orphan frees itself
			pit_pkg::ST_EXIT_FIN: begin
				meta_we    = 1'b1;
				meta_waddr = cur_idx;
				meta_wdata = '{used: (meta_q.parent != INIT_PID),
					exited: (meta_q.parent != INIT_PID), parent: meta_q.parent};
				st_we      = 1'b1;
				st_waddr   = cur_idx;
				st_wdata   = xval_q;
				rsp        = 1'b1;
				state_d    = pit_pkg::ST_IDLE;
			end

			pit_pkg::ST_ALLOC_SCAN: begin
				meta_re    = rd_ok;
				meta_raddr = rd_idx_q;
				rd_idx_d   = AW'(rd_idx_q + 1'b1);
				chk_vld_d  = 1'b1;
				if (chk_vld_s1) begin
					if (!m.used) begin
						meta_we    = 1'b1;
						meta_wdata = '{used: 1'b1, exited: 1'b0, parent: cur_q};
						st_we      = 1'b1;
						st_waddr   = chk_idx_s1;
						st_wdata   = pit_pkg::STATUS_NONE;
						rsp        = 1'b1;
						rsp_pid    = RW'(chk_idx_s1);
						state_d    = pit_pkg::ST_IDLE;
					end else if (chk_idx_s1 == LAST_IDX) begin
						rsp     = 1'b1;
						rsp_err = pit_pkg::ERR_NOFREE;
						state_d = pit_pkg::ST_IDLE;
					end
				end
			end

			// target entry arrives, fetch the caller entry next
			pit_pkg::ST_WAIT_T: begin
				meta_d     = m;
				meta_re    = 1'b1;
				meta_raddr = cur_idx;
				state_d    = pit_pkg::ST_WAIT_C;
			end

			pit_pkg::ST_WAIT_C: begin
				rsp     = 1'b1;
				state_d = pit_pkg::ST_IDLE;
				if (!meta_q.used || !m.used) begin
					rsp_err = pit_pkg::ERR_NOSUCH;
				end else if (meta_q.parent != cur_q) begin
					rsp_err = pit_pkg::ERR_NOTCHILD;
				end else if (!meta_q.exited) begin
					rsp_err = pit_pkg::ERR_MUSTWAIT;
				end else begin
					rsp_stat = st_rdata;
				end
			end

			default: begin
				state_d = pit_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pit_pkg::ST_CLEAR;
			rd_idx_q   <= '0;
			chk_vld_s1 <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_idx_q   <= rd_idx_d;
			chk_vld_s1 <= chk_vld_d;
			done_q     <= rsp;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q  <= current_pid;
			tgt_q  <= target_pid;
			xval_q <= exit_value;
		end
		meta_q     <= meta_d;
		chk_idx_s1 <= rd_idx_q;
		if (rsp) begin
			err_q  <= rsp_err;
			rpid_q <= rsp_pid;
			stat_q <= rsp_stat;
		end
	end

	assign done         = done_q;
	assign error_code   = err_q;
	assign result_pid   = rpid_q;
	assign status_value = stat_q;

endmodule

`default_nettype wire

// ----- sv/pit_checker.sv -----
// port-level checks of the process id table, bound to the top level
`default_nettype none

`include "process_id_table_macros.svh"

module pit_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [2:0]  error_code,
	input wire logic [8:0]  result_pid,
	input wire logic [31:0] status_value
);

	// an accepted item either answers at once or holds the block busy
	`PIT_ASSERT_NEXT(a_accept_busy, start && !busy, busy || done, "item accepted but block idle without result")

	`PIT_ASSERT(a_err_range, !done || (error_code <= pit_pkg::ERR_INVALID), "error code out of range")

	// a failed request never hands out an id
	`PIT_ASSERT(a_fail_no_pid, !done || (error_code == pit_pkg::ERR_OK) || (result_pid == pit_pkg::RPID_NONE), "id given on a failed request")

	// an allocate result never carries a status
	`PIT_ASSERT(a_pid_no_status, !done || (result_pid == pit_pkg::RPID_NONE) || (status_value == '0), "status given with an allocated id")

endmodule

bind process_id_table pit_checker u_pit_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.error_code  (error_code),
	.result_pid  (result_pid),
	.status_value(status_value)
);

`default_nettype wire
